@@ rtl/core/flow_vector_max_magnitude_pool_top_macros.svh @@
// assertion macros for the flow vector max magnitude pool checker
// expects clk and rst_n in the scope of use
`ifndef FLOW_VECTOR_MAX_MAGNITUDE_POOL_TOP_MACROS_SVH
`define FLOW_VECTOR_MAX_MAGNITUDE_POOL_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define FVMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fvmp check failed");

// next-cycle implication, off during reset
`define FVMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fvmp check failed");

// next-cycle implication, live through reset
`define FVMP_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fvmp reset check failed");

`endif

@@ rtl/core/fvmp_pkg.sv @@
// shared types and constants of the flow vector max magnitude pool
// no dependencies
`default_nettype none

package fvmp_pkg;

    localparam int COMP_W        = 16;
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int MIN_DIM       = 2;
    localparam int DIM_W         = 9;
    localparam int DIM_RESET     = 240;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int OUT_W         = COL_W - 1;
    localparam int SQ_W          = 2 * COMP_W - 1;
    localparam int MAG_W         = 2 * COMP_W;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
    } vec_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        vec_t             cur;
        logic             right;
        logic [OUT_W-1:0] ocol;
        logic [OUT_W-1:0] orow;
        logic             done;
    } pool_meta_t;

endpackage

`default_nettype wire

@@ rtl/core/flow_if.sv @@
// input channel of flow vectors, valid/ready handshake
// depends on fvmp_pkg
`default_nettype none

interface flow_if;
    import fvmp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] flow_x;
    logic signed [COMP_W-1:0] flow_y;

    modport source (output valid, output flow_x, output flow_y, input ready);
    modport sink   (input valid, input flow_x, input flow_y, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pool_if.sv @@
// output channel of pooled vectors, valid/ready handshake
// depends on fvmp_pkg
`default_nettype none

interface pool_if;
    import fvmp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] pooled_x;
    logic signed [COMP_W-1:0] pooled_y;
    logic [OUT_W-1:0]         pooled_col;
    logic [OUT_W-1:0]         pooled_row;
    logic                     frame_done;

    modport source (
        output valid, output pooled_x, output pooled_y, output pooled_col,
        output pooled_row, output frame_done, input ready
    );
    modport sink (
        input valid, input pooled_x, input pooled_y, input pooled_col,
        input pooled_row, input frame_done, output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/fvmp_ram.sv @@
// generic single-clock ram, one write port, one read port, registered read
// no dependencies
`default_nettype none

module fvmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/fvmp_regs.sv @@
// apb register file: frame_width and frame_height, clamped copies for the datapath
// depends on fvmp_pkg
`default_nettype none

module fvmp_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fvmp_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fvmp_pkg::APB_DW-1:0]   pwdata,
    output logic      [fvmp_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output fvmp_pkg::cfg_t                     cfg
);
    import fvmp_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             wr;
    reg_idx_t         idx;

    assign idx    = reg_idx_t'(paddr[APB_AW-1]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(DIM_RESET);
            height_reg <= DIM_W'(DIM_RESET);
        end
        else if (wr)
        begin
            case (idx)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (width_reg < DIM_W'(MIN_DIM))
        begin
            cfg.width = DIM_W'(MIN_DIM);
        end
        else if (width_reg > DIM_W'(MAX_WIDTH))
        begin
            cfg.width = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end

        if (height_reg < DIM_W'(MIN_DIM))
        begin
            cfg.height = DIM_W'(MIN_DIM);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            cfg.height = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end

        cfg.restart = wr;
    end

endmodule

`default_nettype wire

@@ rtl/core/fvmp_front.sv @@
// raster position tracking and top-row line buffer access
// depends on fvmp_pkg, flow_if, fvmp_ram
`default_nettype none

module fvmp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fvmp_pkg::cfg_t       cfg,
    flow_if.sink                      flow,
    output logic                      s1_valid,
    output fvmp_pkg::pool_meta_t      s1_meta,
    output fvmp_pkg::vec_t            top_vec,
    input  wire logic                 s1_ready
);
    import fvmp_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             s1_valid_reg;
    pool_meta_t       meta_reg;
    pool_meta_t       meta_next;
    logic             accept;
    logic             odd_row;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic [OUT_W-1:0] ocol_last;
    logic [OUT_W-1:0] orow_last;
    logic [2*COMP_W-1:0] ram_rdata;
    vec_t             cur;

    assign flow.ready = !s1_valid_reg || s1_ready;
    assign accept     = flow.valid && flow.ready;
    assign odd_row    = row_reg[0];
    assign cur        = '{x: flow.flow_x, y: flow.flow_y};

    assign col_last  = COL_W'(cfg.width - DIM_W'(1));
    assign row_last  = ROW_W'(cfg.height - DIM_W'(1));
    assign ocol_last = OUT_W'((cfg.width >> 1) - DIM_W'(1));
    assign orow_last = OUT_W'((cfg.height >> 1) - DIM_W'(1));

    always_comb
    begin
        meta_next.cur   = cur;
        meta_next.right = col_reg[0];
        meta_next.ocol  = col_reg[COL_W-1:1];
        meta_next.orow  = row_reg[ROW_W-1:1];
        meta_next.done  = (col_reg[COL_W-1:1] == ocol_last)
                          && (row_reg[ROW_W-1:1] == orow_last);
    end

    // even rows fill the line buffer, odd rows read it back
    fvmp_ram #(
        .WIDTH (2 * COMP_W),
        .DEPTH (MAX_WIDTH)
    ) u_top_row (
        .clk   (clk),
        .we    (accept && !odd_row),
        .waddr (col_reg),
        .wdata (cur),
        .re    (accept && odd_row),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_reg == col_last)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == row_last) ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end

            if (!s1_valid_reg || s1_ready)
            begin
                s1_valid_reg <= accept && odd_row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && odd_row)
        begin
            meta_reg <= meta_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_meta  = meta_reg;
    assign top_vec  = vec_t'(ram_rdata);

endmodule

`default_nettype wire

@@ rtl/core/fvmp_pick.sv @@
// magnitude compare pipeline, left winner hold and output register
// depends on fvmp_pkg, pool_if
`default_nettype none

module fvmp_pick (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s1_valid,
    input  wire fvmp_pkg::pool_meta_t s1_meta,
    input  wire fvmp_pkg::vec_t       top_vec,
    output logic                      s1_ready,
    pool_if.source                    pooled
);
    import fvmp_pkg::*;

    function automatic logic [SQ_W-1:0] square(input logic signed [COMP_W-1:0] a);
        logic signed [2*COMP_W-1:0] ext;
        logic signed [2*COMP_W-1:0] prod;
        ext  = (2*COMP_W)'(a);
        prod = ext * ext;
        return prod[SQ_W-1:0];
    endfunction

    // stage 2: squares
    logic             v2_reg;
    pool_meta_t       meta2_reg;
    vec_t             top2_reg;
    logic [SQ_W-1:0]  sq_tx_reg;
    logic [SQ_W-1:0]  sq_ty_reg;
    logic [SQ_W-1:0]  sq_cx_reg;
    logic [SQ_W-1:0]  sq_cy_reg;

    // stage 3: column winner
    logic             v3_reg;
    pool_meta_t       meta3_reg;
    vec_t             win3_reg;
    logic [MAG_W-1:0] mag3_reg;

    // window state and output
    vec_t             left_reg;
    logic [MAG_W-1:0] left_mag_reg;
    logic             out_valid_reg;
    vec_t             out_vec_reg;
    logic [OUT_W-1:0] out_col_reg;
    logic [OUT_W-1:0] out_row_reg;
    logic             out_done_reg;

    logic             out_free;
    logic             r3;
    logic             r2;
    logic [MAG_W-1:0] mag_top;
    logic [MAG_W-1:0] mag_cur;
    logic             top_wins;

    assign out_free = !out_valid_reg || pooled.ready;
    assign r3       = !v3_reg || !meta3_reg.right || out_free;
    assign r2       = !v2_reg || r3;
    assign s1_ready = r2;

    assign mag_top  = MAG_W'(sq_tx_reg) + MAG_W'(sq_ty_reg);
    assign mag_cur  = MAG_W'(sq_cx_reg) + MAG_W'(sq_cy_reg);
    assign top_wins = mag_top > mag_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            left_mag_reg  <= '0;
        end
        else
        begin
            if (r2)
            begin
                v2_reg <= s1_valid;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= v3_reg && meta3_reg.right;
            end
            if (v3_reg && !meta3_reg.right)
            begin
                left_reg     <= win3_reg;
                left_mag_reg <= mag3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r2 && s1_valid)
        begin
            meta2_reg <= s1_meta;
            top2_reg  <= top_vec;
            sq_tx_reg <= square(top_vec.x);
            sq_ty_reg <= square(top_vec.y);
            sq_cx_reg <= square(s1_meta.cur.x);
            sq_cy_reg <= square(s1_meta.cur.y);
        end
        if (r3 && v2_reg)
        begin
            meta3_reg <= meta2_reg;
            win3_reg  <= top_wins ? top2_reg : meta2_reg.cur;
            mag3_reg  <= top_wins ? mag_top : mag_cur;
        end
        if (out_free && v3_reg && meta3_reg.right)
        begin
            out_vec_reg  <= (left_mag_reg > mag3_reg) ? left_reg : win3_reg;
            out_col_reg  <= meta3_reg.ocol;
            out_row_reg  <= meta3_reg.orow;
            out_done_reg <= meta3_reg.done;
        end
    end

    assign pooled.valid      = out_valid_reg;
    assign pooled.pooled_x   = out_vec_reg.x;
    assign pooled.pooled_y   = out_vec_reg.y;
    assign pooled.pooled_col = out_col_reg;
    assign pooled.pooled_row = out_row_reg;
    assign pooled.frame_done = out_done_reg;

endmodule

`default_nettype wire

@@ rtl/core/flow_vector_max_magnitude_pool_top.sv @@
// top level of the 2x2 stride-2 max magnitude pool for flow vectors
// depends on fvmp_pkg, flow_if, pool_if, fvmp_regs, fvmp_front, fvmp_pick
//
//   channel   kind        beat contents
//   flow      sink        flow_x, flow_y (signed q8.8)
//   pooled    source      pooled_x, pooled_y, pooled_col, pooled_row, frame_done
//   apb       register    frame_width at 0x0, frame_height at 0x4
//
// one flow beat per clock while the pooled side does not stall; the top-row line buffer is written in even rows and
// read in odd rows through one ram with a registered read
// a pooled beat passes the s1, stage 2, stage 3 and output registers after the flow beat that closes its window
// reset clears position, pipeline valids and left winner; line buffer content is not cleared
// a held pooled beat stalls the flow side only once the compare pipeline is full

`default_nettype none

module flow_vector_max_magnitude_pool_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fvmp_pkg::APB_AW-1:0] paddr,
    input  wire logic [fvmp_pkg::APB_DW-1:0] pwdata,
    output logic      [fvmp_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    flow_if.sink                             flow,
    pool_if.source                           pooled
);
    import fvmp_pkg::*;

    cfg_t       cfg;
    logic       s1_valid;
    logic       s1_ready;
    pool_meta_t s1_meta;
    vec_t       top_vec;

    fvmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fvmp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .flow     (flow),
        .s1_valid (s1_valid),
        .s1_meta  (s1_meta),
        .top_vec  (top_vec),
        .s1_ready (s1_ready)
    );

    fvmp_pick u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_meta  (s1_meta),
        .top_vec  (top_vec),
        .s1_ready (s1_ready),
        .pooled   (pooled)
    );

endmodule

`default_nettype wire

@@ rtl/core/fvmp_checker.sv @@
// port-level checks of the flow vector max magnitude pool, bound to the top level
// depends on fvmp_pkg and flow_vector_max_magnitude_pool_top_macros.svh
`default_nettype none

`include "flow_vector_max_magnitude_pool_top_macros.svh"

module fvmp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        pready,
    input wire logic                        flow_ready,
    input wire logic                        pooled_valid,
    input wire logic                        pooled_ready,
    input wire logic [fvmp_pkg::COMP_W-1:0] pooled_x,
    input wire logic [fvmp_pkg::COMP_W-1:0] pooled_y,
    input wire logic                        frame_done
);

    `FVMP_ASSERT_SAME(a_pready_high, 1'b1, pready)

    // an empty or draining output leaves room for the next flow beat
    `FVMP_ASSERT_SAME(a_ready_when_out_free, !pooled_valid || pooled_ready, flow_ready)

    `FVMP_ASSERT_NEXT(a_stall_holds, pooled_valid && !pooled_ready, pooled_valid && $stable(pooled_x) && $stable(pooled_y) && $stable(frame_done))

    `FVMP_ASSERT_RESET(a_quiet_after_reset, !rst_n, !pooled_valid)

endmodule

bind flow_vector_max_magnitude_pool_top fvmp_checker u_fvmp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .flow_ready   (flow.ready),
    .pooled_valid (pooled.valid),
    .pooled_ready (pooled.ready),
    .pooled_x     (pooled.pooled_x),
    .pooled_y     (pooled.pooled_y),
    .frame_done   (pooled.frame_done)
);

`default_nettype wire

@@ tb/tb_flow_vector_max_magnitude_pool_top.sv @@
// testbench for the 2x2 stride-2 max magnitude pool of flow vectors
// random flow and pooled pacing, apb frame size changes, beat-by-beat pooled checks
// depends on fvmp_pkg, flow_if, pool_if and flow_vector_max_magnitude_pool_top

module tb_flow_vector_max_magnitude_pool_top;
    import fvmp_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 16;
    localparam int FLOW_TARGET = 1900;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic [OUT_W-1:0]         col;
        logic [OUT_W-1:0]         row;
        logic                     done;
    } pooled_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    flow_if flow ();
    pool_if pooled ();

    flow_vector_max_magnitude_pool_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .flow    (flow),
        .pooled  (pooled)
    );

    always #5 clk = ~clk;

    // pool state kept on the testbench side
    vec_t line_store [MAX_WIDTH];
    vec_t left_win = '0;
    int unsigned pool_col = 0;
    int unsigned pool_row = 0;
    logic [DIM_W-1:0] frame_width_reg = DIM_W'(DIM_RESET);
    logic [DIM_W-1:0] frame_height_reg = DIM_W'(DIM_RESET);

    vec_t flow_backlog [$];
    pooled_beat_t pending_pooled [$];

    int flow_items = 0;
    int flow_beats = 0;
    int pooled_beats = 0;
    int mismatch_count = 0;
    int frame_settings = 0;
    int quiet_cycles = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    function automatic longint vec_energy(vec_t v);
        longint sx;
        longint sy;
        sx = $signed(v.x);
        sy = $signed(v.y);
        return sx * sx + sy * sy;
    endfunction

    // a wins only when strictly larger
    function automatic vec_t stronger_vec(vec_t a, vec_t b);
        return (vec_energy(a) > vec_energy(b)) ? a : b;
    endfunction

    function automatic void predict_pooled(vec_t cur);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        vec_t best;
        pooled_beat_t want;
        w = (frame_width_reg < MIN_DIM) ? MIN_DIM :
            (frame_width_reg > MAX_WIDTH) ? MAX_WIDTH : frame_width_reg;
        h = (frame_height_reg < MIN_DIM) ? MIN_DIM :
            (frame_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : frame_height_reg;
        c = (pool_col >= w) ? 0 : pool_col;
        r = (pool_row >= h) ? 0 : pool_row;
        if (r[0] == 1'b0)
        begin
            line_store[c] = cur;
        end
        else if (c[0] == 1'b0)
        begin
            left_win = stronger_vec(line_store[c], cur);
        end
        else
        begin
            best = stronger_vec(left_win, stronger_vec(line_store[c], cur));
            want.x = best.x;
            want.y = best.y;
            want.col = OUT_W'(c >> 1);
            want.row = OUT_W'(r >> 1);
            want.done = ((c >> 1) == w / 2 - 1) && ((r >> 1) == h / 2 - 1);
            pending_pooled = {pending_pooled, want};
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        pool_col = c;
        pool_row = r;
    endfunction

    function automatic int draw_idle(inout bit calm);
        if ($urandom_range(0, 47) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic signed [COMP_W-1:0] edge_component();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h8001;
            3: return 16'hffff;
            4: return 16'h0000;
            5: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic queue_flow(input int x, input int y);
        vec_t v;
        v.x = COMP_W'(x);
        v.y = COMP_W'(y);
        flow_backlog = {flow_backlog, v};
        flow_items++;
    endtask

    task automatic queue_random(input int count);
        vec_t v;
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1:
                begin
                    // equal magnitude 25 in many shapes, to hit the strict compares
                    {v.x, v.y} = $urandom_range(0, 1) ? {16'sd3, 16'sd4} : {16'sd5, 16'sd0};
                    if ($urandom_range(0, 1))
                        {v.x, v.y} = {v.y, v.x};
                    if ($urandom_range(0, 1))
                        v.x = -v.x;
                    if ($urandom_range(0, 1))
                        v.y = -v.y;
                end
                2:
                begin
                    v.x = edge_component();
                    v.y = edge_component();
                end
                default:
                begin
                    v.x = 16'($urandom_range(0, 14)) - 16'd7;
                    v.y = 16'($urandom_range(0, 14)) - 16'd7;
                end
            endcase
            queue_flow($signed(v.x), $signed(v.y));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (flow_backlog.size() != 0 || flow.valid || pending_pooled.size() != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {(APB_DW - DIM_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: frame_width_reg = value;
            REG_FRAME_HEIGHT: frame_height_reg = value;
            default: ;
        endcase
        pool_col = 0;
        pool_row = 0;
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_drained();
        // left-column beats of odd rows give no pooled beat and may still be in flight
        repeat (8) @(posedge clk);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        frame_settings++;
    endtask

    // flow driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow.valid <= 1'b0;
            flow.flow_x <= '0;
            flow.flow_y <= '0;
            send_wait <= 0;
        end
        else
        begin
            int gap;
            vec_t seen;
            vec_t next_vec;
            gap = send_wait;
            if (flow.valid && flow.ready)
            begin
                seen.x = flow.flow_x;
                seen.y = flow.flow_y;
                predict_pooled(seen);
                flow_beats++;
                gap = draw_idle(send_calm);
            end
            if (flow.valid && !flow.ready)
            begin
            end
            else if (gap > 0)
            begin
                flow.valid <= 1'b0;
                send_wait <= gap - 1;
            end
            else if (flow_backlog.size() != 0)
            begin
                next_vec = flow_backlog.pop_front();
                flow.valid <= 1'b1;
                flow.flow_x <= next_vec.x;
                flow.flow_y <= next_vec.y;
                send_wait <= 0;
            end
            else
            begin
                flow.valid <= 1'b0;
                send_wait <= 0;
            end
        end
    end

    // pooled monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pooled.ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            int stall;
            pooled_beat_t want;
            stall = recv_wait;
            if (pooled.valid && pooled.ready)
            begin
                pooled_beats++;
                if (pending_pooled.size() == 0)
                begin
                    report_mismatch("pooled beat with nothing pending");
                end
                else
                begin
                    want = pending_pooled.pop_front();
                    if (pooled.pooled_x !== want.x)
                        report_mismatch($sformatf("pooled_x %0d, want %0d",
                            pooled.pooled_x, want.x));
                    if (pooled.pooled_y !== want.y)
                        report_mismatch($sformatf("pooled_y %0d, want %0d",
                            pooled.pooled_y, want.y));
                    if (pooled.pooled_col !== want.col)
                        report_mismatch($sformatf("pooled_col %0d, want %0d",
                            pooled.pooled_col, want.col));
                    if (pooled.pooled_row !== want.row)
                        report_mismatch($sformatf("pooled_row %0d, want %0d",
                            pooled.pooled_row, want.row));
                    if (pooled.frame_done !== want.done)
                        report_mismatch($sformatf("frame_done %0b, want %0b",
                            pooled.frame_done, want.done));
                end
                stall = draw_idle(recv_calm);
            end
            if (stall > 0)
            begin
                pooled.ready <= 1'b0;
                recv_wait <= stall - 1;
            end
            else
            begin
                pooled.ready <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (flow.valid && flow.ready) || (pooled.valid && pooled.ready)
            || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int span;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        flow.valid = 1'b0;
        flow.flow_x = '0;
        flow.flow_y = '0;
        pooled.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset frame size: first row plus two windows of the second
        queue_random(DIM_RESET + 4);

        // one window per frame: ties, each corner winning, extremes
        set_frame(2, 2);
        queue_flow(3, 4);           queue_flow(5, 0);
        queue_flow(0, 5);           queue_flow(-4, 3);
        queue_flow(-32768, -32768); queue_flow(1, 0);
        queue_flow(0, -1);          queue_flow(7, 7);
        queue_flow(1, 1);           queue_flow(32767, -32768);
        queue_flow(2, 2);           queue_flow(-3, 0);
        queue_flow(0, 1);           queue_flow(0, -1);
        queue_flow(-32768, 32767);  queue_flow(32767, 0);
        queue_flow(-1, -1);         queue_flow(1, 1);
        queue_flow(1, -1);          queue_flow(-32768, 0);
        queue_flow(0, -32768);      queue_flow(100, 0);
        queue_flow(5, 5);           queue_flow(-32768, 0);

        // sizes below the minimum act as the minimum
        set_frame(0, 1);
        queue_random(60);

        // widest frame, one pooled row
        set_frame(MAX_WIDTH, 0);
        queue_random(2 * MAX_WIDTH);

        // tallest frame, sender held once until everything has come out
        set_frame(1, 511);
        queue_random(MAX_HEIGHT);
        wait_drained();
        queue_random(MAX_HEIGHT);

        while (flow_items < FLOW_TARGET)
        begin
            w = $urandom_range(0, 14);
            h = $urandom_range(0, 10);
            span = ((w < MIN_DIM) ? MIN_DIM : w) * ((h < MIN_DIM) ? MIN_DIM : h);
            set_frame(w, h);
            queue_random(span * $urandom_range(1, 2) + $urandom_range(0, 2 * span));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d flow beats in, %0d pooled beats checked, %0d frame size settings",
            flow_beats, pooled_beats, frame_settings);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ flow_vector_max_magnitude_pool_top.f @@
+incdir+rtl/core
rtl/core/fvmp_pkg.sv
rtl/core/flow_if.sv
rtl/core/pool_if.sv
rtl/core/fvmp_ram.sv
rtl/core/fvmp_regs.sv
rtl/core/fvmp_front.sv
rtl/core/fvmp_pick.sv
rtl/core/flow_vector_max_magnitude_pool_top.sv
rtl/core/fvmp_checker.sv
tb/tb_flow_vector_max_magnitude_pool_top.sv
